FILE: rtl/core/kci_pkg.sv
// ----------------------------------------------------------------------------
// kci_pkg
// Shared widths, curve mode codes and pipeline payload types for the
// keyframe curve interpolator.
// ----------------------------------------------------------------------------
package kci_pkg;

    localparam int VAL_W    = 32;
    localparam int POS_W    = 17;
    localparam int FRAC_W   = 16;
    localparam int LANES    = 4;
    localparam int SQ_W     = 2 * POS_W;
    localparam int PR_W     = SQ_W + POS_W;
    localparam int CU_W     = 49;
    localparam int EXT_W    = 52;
    localparam int WGT_W    = 50;
    localparam int WGT_FRAC = 48;
    localparam int WLO_W    = 25;
    localparam int WHI_W    = WGT_W - WLO_W;
    localparam int PHI_W    = VAL_W + WHI_W;
    localparam int PLO_W    = VAL_W + WLO_W + 1;
    localparam int ACC_W    = 84;
    localparam int INT_FRAC = WGT_FRAC + FRAC_W;
    localparam int RND_W    = ACC_W - WGT_FRAC;
    localparam int WHL_W    = ACC_W - INT_FRAC;

    localparam logic [POS_W-1:0] POS_ONE = POS_W'(1) << FRAC_W;

    typedef enum logic [1:0] {
        OP_HOLD    = 2'd0,
        OP_LINEAR  = 2'd1,
        OP_BEZIER  = 2'd2,
        OP_HERMITE = 2'd3
    } curve_op_t;

    typedef logic [LANES-1:0][VAL_W-1:0] val_vec_t;
    typedef logic [LANES-1:0][WGT_W-1:0] wgt_vec_t;

    typedef struct packed {
        logic     whole;
        val_vec_t val;
    } side_t;

endpackage

FILE: rtl/core/keyframe_curve_interpolator.sv
// ----------------------------------------------------------------------------
// keyframe_curve_interpolator
// Pipeline: 3 weight stages, 4 multiply-accumulate stages and 1
//   round/saturate output stage.
// Throughput: one item per cycle; the whole pipeline holds while the output
//   register is full and not taken. Reset clears all valid bits; no state.
// ----------------------------------------------------------------------------
module keyframe_curve_interpolator import kci_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_operation,
    input  logic              s_integer_track,
    input  logic [VAL_W-1:0]  s_left_value,
    input  logic [VAL_W-1:0]  s_left_out_tangent,
    input  logic [VAL_W-1:0]  s_right_in_tangent,
    input  logic [VAL_W-1:0]  s_right_value,
    input  logic [POS_W-1:0]  s_blend_position,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [VAL_W-1:0]  m_curve_value,
    output logic              m_saturated
);

    logic                    advance;
    side_t                   in_side;
    curve_op_t               in_op;
    logic                    w_vld;
    wgt_vec_t                w_wgt;
    side_t                   w_side;
    logic                    a_vld;
    logic                    a_whole;
    logic signed [ACC_W-1:0] a_acc;

    assign advance = !m_valid || m_ready;
    assign s_ready = advance;
    assign in_op   = curve_op_t'(s_operation);

    always_comb begin
        in_side.whole  = s_integer_track;
        in_side.val[0] = s_left_value;
        in_side.val[1] = s_left_out_tangent;
        in_side.val[2] = s_right_in_tangent;
        in_side.val[3] = s_right_value;
    end

    kci_weight u_weight (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (advance),
        .in_vld   (s_valid),
        .in_op    (in_op),
        .in_pos   (s_blend_position),
        .in_side  (in_side),
        .out_vld  (w_vld),
        .out_wgt  (w_wgt),
        .out_side (w_side)
    );

    kci_mac u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (advance),
        .in_vld    (w_vld),
        .in_wgt    (w_wgt),
        .in_side   (w_side),
        .out_vld   (a_vld),
        .out_whole (a_whole),
        .out_acc   (a_acc)
    );

    kci_round u_round (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (advance),
        .in_vld    (a_vld),
        .in_whole  (a_whole),
        .in_acc    (a_acc),
        .out_vld   (m_valid),
        .out_value (m_curve_value),
        .out_sat   (m_saturated)
    );

endmodule

FILE: rtl/core/kci_weight.sv
// ----------------------------------------------------------------------------
// kci_weight
// Three-stage basis weight generator: powers of t and 1-t, then the signed
// Q1.48 weights of the selected curve mode.
// ----------------------------------------------------------------------------
module kci_weight import kci_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_vld,
    input  curve_op_t        in_op,
    input  logic [POS_W-1:0] in_pos,
    input  side_t            in_side,
    output logic             out_vld,
    output wgt_vec_t         out_wgt,
    output side_t            out_side
);

    logic             s1_vld_reg, s1_vld_next;
    curve_op_t        s1_op_reg;
    side_t            s1_side_reg;
    logic [POS_W-1:0] s1_t_reg, s1_t_next, s1_u_reg, s1_u_next;
    logic [SQ_W-1:0]  s1_tt_reg, s1_tt_next, s1_uu_reg, s1_uu_next;

    logic             s2_vld_reg, s2_vld_next;
    curve_op_t        s2_op_reg;
    side_t            s2_side_reg;
    logic [POS_W-1:0] s2_t_reg, s2_u_reg;
    logic [SQ_W-1:0]  s2_tt_reg;
    logic [CU_W-1:0]  s2_ttt_reg, s2_ttt_next, s2_uuu_reg, s2_uuu_next;
    logic [CU_W-1:0]  s2_tuu_reg, s2_tuu_next, s2_ttu_reg, s2_ttu_next;

    logic             s3_vld_reg, s3_vld_next;
    side_t            s3_side_reg;
    wgt_vec_t         s3_wgt_reg, s3_wgt_next;

    logic [PR_W-1:0]  ttt_full, uuu_full, tuu_full, ttu_full;

    logic signed [EXT_W-1:0] t3e, u3e, tu2e, t2ue, t2s, tsh, ush, one_w;

    // stage 1: clamp t, squares
    always_comb begin
        s1_t_next  = (in_pos > POS_ONE) ? POS_ONE : in_pos;
        s1_u_next  = POS_ONE - s1_t_next;
        s1_tt_next = SQ_W'(s1_t_next) * SQ_W'(s1_t_next);
        s1_uu_next = SQ_W'(s1_u_next) * SQ_W'(s1_u_next);
    end

    // stage 2: cubes and mixed terms
    assign ttt_full = PR_W'(s1_tt_reg) * PR_W'(s1_t_reg);
    assign uuu_full = PR_W'(s1_uu_reg) * PR_W'(s1_u_reg);
    assign tuu_full = PR_W'(s1_uu_reg) * PR_W'(s1_t_reg);
    assign ttu_full = PR_W'(s1_tt_reg) * PR_W'(s1_u_reg);

    always_comb begin
        s2_ttt_next = ttt_full[CU_W-1:0];
        s2_uuu_next = uuu_full[CU_W-1:0];
        s2_tuu_next = tuu_full[CU_W-1:0];
        s2_ttu_next = ttu_full[CU_W-1:0];
    end

    // stage 3: weights per mode
    always_comb begin
        t3e   = signed'(EXT_W'(s2_ttt_reg));
        u3e   = signed'(EXT_W'(s2_uuu_reg));
        tu2e  = signed'(EXT_W'(s2_tuu_reg));
        t2ue  = signed'(EXT_W'(s2_ttu_reg));
        t2s   = signed'(EXT_W'(s2_tt_reg) << FRAC_W);
        tsh   = signed'(EXT_W'(s2_t_reg) << (2 * FRAC_W));
        ush   = signed'(EXT_W'(s2_u_reg) << (2 * FRAC_W));
        one_w = signed'(EXT_W'(1) << WGT_FRAC);
        s3_wgt_next = '0;
        case (s2_op_reg)
            OP_HOLD: begin
                s3_wgt_next[0] = WGT_W'(one_w);
            end
            OP_LINEAR: begin
                s3_wgt_next[0] = WGT_W'(ush);
                s3_wgt_next[3] = WGT_W'(tsh);
            end
            OP_BEZIER: begin
                s3_wgt_next[0] = WGT_W'(u3e);
                s3_wgt_next[1] = WGT_W'((tu2e <<< 1) + tu2e);
                s3_wgt_next[2] = WGT_W'((t2ue <<< 1) + t2ue);
                s3_wgt_next[3] = WGT_W'(t3e);
            end
            OP_HERMITE: begin
                s3_wgt_next[0] = WGT_W'((t3e <<< 1) - ((t2s <<< 1) + t2s) + one_w);
                s3_wgt_next[1] = WGT_W'(t3e - (t2s <<< 1) + tsh);
                s3_wgt_next[2] = WGT_W'(t3e - t2s);
                s3_wgt_next[3] = WGT_W'(((t2s <<< 1) + t2s) - (t3e <<< 1));
            end
            default: begin
                s3_wgt_next = '0;
            end
        endcase
    end

    always_comb begin
        s1_vld_next = en ? in_vld     : s1_vld_reg;
        s2_vld_next = en ? s1_vld_reg : s2_vld_reg;
        s3_vld_next = en ? s2_vld_reg : s3_vld_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end else begin
            s1_vld_reg <= s1_vld_next;
            s2_vld_reg <= s2_vld_next;
            s3_vld_reg <= s3_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_op_reg   <= in_op;
            s1_side_reg <= in_side;
            s1_t_reg    <= s1_t_next;
            s1_u_reg    <= s1_u_next;
            s1_tt_reg   <= s1_tt_next;
            s1_uu_reg   <= s1_uu_next;

            s2_op_reg   <= s1_op_reg;
            s2_side_reg <= s1_side_reg;
            s2_t_reg    <= s1_t_reg;
            s2_u_reg    <= s1_u_reg;
            s2_tt_reg   <= s1_tt_reg;
            s2_ttt_reg  <= s2_ttt_next;
            s2_uuu_reg  <= s2_uuu_next;
            s2_tuu_reg  <= s2_tuu_next;
            s2_ttu_reg  <= s2_ttu_next;

            s3_side_reg <= s2_side_reg;
            s3_wgt_reg  <= s3_wgt_next;
        end
    end

    assign out_vld  = s3_vld_reg;
    assign out_wgt  = s3_wgt_reg;
    assign out_side = s3_side_reg;

endmodule

FILE: rtl/core/kci_mac.sv
// ----------------------------------------------------------------------------
// kci_mac
// Four-stage weighted sum: split partial products per lane, lane merge,
// pairwise add, final add into an exact wide accumulator.
// ----------------------------------------------------------------------------
module kci_mac import kci_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_vld,
    input  wgt_vec_t                in_wgt,
    input  side_t                   in_side,
    output logic                    out_vld,
    output logic                    out_whole,
    output logic signed [ACC_W-1:0] out_acc
);

    logic                    s4_vld_reg, s4_vld_next;
    logic                    s4_whole_reg;
    logic signed [PHI_W-1:0] s4_hi_reg [LANES];
    logic signed [PHI_W-1:0] s4_hi_next [LANES];
    logic signed [PLO_W-1:0] s4_lo_reg [LANES];
    logic signed [PLO_W-1:0] s4_lo_next [LANES];

    logic                    s5_vld_reg, s5_vld_next;
    logic                    s5_whole_reg;
    logic signed [ACC_W-1:0] s5_lane_reg [LANES];
    logic signed [ACC_W-1:0] s5_lane_next [LANES];

    logic                    s6_vld_reg, s6_vld_next;
    logic                    s6_whole_reg;
    logic signed [ACC_W-1:0] s6_a_reg, s6_a_next, s6_b_reg, s6_b_next;

    logic                    s7_vld_reg, s7_vld_next;
    logic                    s7_whole_reg;
    logic signed [ACC_W-1:0] s7_acc_reg, s7_acc_next;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            s4_hi_next[i] = PHI_W'(signed'(in_side.val[i]))
                          * PHI_W'(signed'(in_wgt[i][WGT_W-1:WLO_W]));
            s4_lo_next[i] = PLO_W'(signed'(in_side.val[i]))
                          * signed'(PLO_W'(in_wgt[i][WLO_W-1:0]));
            s5_lane_next[i] = (ACC_W'(s4_hi_reg[i]) <<< WLO_W) + ACC_W'(s4_lo_reg[i]);
        end
        s6_a_next   = s5_lane_reg[0] + s5_lane_reg[1];
        s6_b_next   = s5_lane_reg[2] + s5_lane_reg[3];
        s7_acc_next = s6_a_reg + s6_b_reg;
    end

    always_comb begin
        s4_vld_next = en ? in_vld     : s4_vld_reg;
        s5_vld_next = en ? s4_vld_reg : s5_vld_reg;
        s6_vld_next = en ? s5_vld_reg : s6_vld_reg;
        s7_vld_next = en ? s6_vld_reg : s7_vld_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            s6_vld_reg <= 1'b0;
            s7_vld_reg <= 1'b0;
        end else begin
            s4_vld_reg <= s4_vld_next;
            s5_vld_reg <= s5_vld_next;
            s6_vld_reg <= s6_vld_next;
            s7_vld_reg <= s7_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s4_whole_reg <= in_side.whole;
            s4_hi_reg    <= s4_hi_next;
            s4_lo_reg    <= s4_lo_next;
            s5_whole_reg <= s4_whole_reg;
            s5_lane_reg  <= s5_lane_next;
            s6_whole_reg <= s5_whole_reg;
            s6_a_reg     <= s6_a_next;
            s6_b_reg     <= s6_b_next;
            s7_whole_reg <= s6_whole_reg;
            s7_acc_reg   <= s7_acc_next;
        end
    end

    assign out_vld   = s7_vld_reg;
    assign out_whole = s7_whole_reg;
    assign out_acc   = s7_acc_reg;

endmodule

FILE: rtl/core/kci_round.sv
// ----------------------------------------------------------------------------
// kci_round
// Output stage: round half up or truncate toward zero, saturate, and hold
// the result item until taken.
// ----------------------------------------------------------------------------
module kci_round import kci_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_vld,
    input  logic                    in_whole,
    input  logic signed [ACC_W-1:0] in_acc,
    output logic                    out_vld,
    output logic [VAL_W-1:0]        out_value,
    output logic                    out_sat
);

    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (WGT_FRAC - 1);

    logic                    vld_reg, vld_next;
    logic [VAL_W-1:0]        value_reg, value_next;
    logic                    sat_reg, sat_next;

    logic signed [ACC_W-1:0] rnd_sum;
    logic signed [RND_W-1:0] rnd;
    logic                    rnd_ovf, rnd_unf;
    logic signed [WHL_W-1:0] whl;
    logic                    whl_ovf, whl_unf;
    logic                    frac_nz;

    always_comb begin
        rnd_sum = in_acc + HALF;
        rnd     = rnd_sum[ACC_W-1:WGT_FRAC];
        rnd_ovf = !rnd[RND_W-1] && (rnd[RND_W-2:VAL_W-1] != '0);
        rnd_unf = rnd[RND_W-1] && (rnd[RND_W-2:VAL_W-1] != '1);

        frac_nz = (in_acc[INT_FRAC-1:0] != '0);
        whl     = in_acc[ACC_W-1:INT_FRAC] + WHL_W'(in_acc[ACC_W-1] && frac_nz);
        whl_ovf = !whl[WHL_W-1] && (whl[WHL_W-2:FRAC_W-1] != '0);
        whl_unf = whl[WHL_W-1] && (whl[WHL_W-2:FRAC_W-1] != '1);

        if (in_whole) begin
            sat_next = whl_ovf || whl_unf;
            if (whl_ovf) begin
                value_next = {1'b0, {(FRAC_W-1){1'b1}}, {FRAC_W{1'b0}}};
            end else if (whl_unf) begin
                value_next = {1'b1, {(VAL_W-1){1'b0}}};
            end else begin
                value_next = {whl[FRAC_W-1:0], {FRAC_W{1'b0}}};
            end
        end else begin
            sat_next = rnd_ovf || rnd_unf;
            if (rnd_ovf) begin
                value_next = {1'b0, {(VAL_W-1){1'b1}}};
            end else if (rnd_unf) begin
                value_next = {1'b1, {(VAL_W-1){1'b0}}};
            end else begin
                value_next = rnd[VAL_W-1:0];
            end
        end
        vld_next = en ? in_vld : vld_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            value_reg <= value_next;
            sat_reg   <= sat_next;
        end
    end

    assign out_vld   = vld_reg;
    assign out_value = value_reg;
    assign out_sat   = sat_reg;

endmodule

FILE: rtl/core/kci_check.sv
// ----------------------------------------------------------------------------
// kci_check
// Port-level checks for the keyframe curve interpolator, bound to the top.
// ----------------------------------------------------------------------------
module kci_check import kci_pkg::*; (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input logic [VAL_W-1:0] m_curve_value,
    input logic             m_saturated
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_curve_value) && $stable(m_saturated))
        else $error("result item changed while stalled");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    a_sat_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturated |->
            (m_curve_value == 32'h7FFF_FFFF) || (m_curve_value == 32'h8000_0000)
            || (m_curve_value == 32'h7FFF_0000))
        else $error("saturated item not at a clamp bound");

    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn && s_valid && s_ready, 8)
        && $past(aresetn && m_ready, 1) && $past(aresetn && m_ready, 2)
        && $past(aresetn && m_ready, 3) && $past(aresetn && m_ready, 4)
        && $past(aresetn && m_ready, 5) && $past(aresetn && m_ready, 6)
        && $past(aresetn && m_ready, 7) |-> m_valid)
        else $error("item did not arrive after eight free cycles");

endmodule

bind keyframe_curve_interpolator kci_check u_kci_check (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_curve_value (m_curve_value),
    .m_saturated   (m_saturated)
);

FILE: tb/curve_result_checker.sv
// ----------------------------------------------------------------------------
// curve_result_checker
// Watches both channels of the keyframe curve interpolator. Every accepted
// segment is evaluated here in exact wide arithmetic (hold, linear, Bezier,
// Hermite; real or integer track) and queued; every accepted result is
// compared field by field with the oldest queued value.
// ----------------------------------------------------------------------------
module curve_result_checker import kci_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_ready,
    input  logic [1:0]       s_operation,
    input  logic             s_integer_track,
    input  logic [VAL_W-1:0] s_left_value,
    input  logic [VAL_W-1:0] s_left_out_tangent,
    input  logic [VAL_W-1:0] s_right_in_tangent,
    input  logic [VAL_W-1:0] s_right_value,
    input  logic [POS_W-1:0] s_blend_position,
    input  logic             m_valid,
    input  logic             m_ready,
    input  logic [VAL_W-1:0] m_curve_value,
    input  logic             m_saturated,
    output int               fail_count,
    output int               pending,
    output int               checked_count,
    output int               saturated_count
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint ONE_POS   = 64'sd65536;
    localparam longint ONE_W48   = 64'sd1 <<< 48;
    localparam longint ONE_W32   = 64'sd1 <<< 32;
    localparam longint Q16_MAX   = 64'sh7FFF_FFFF;
    localparam longint Q16_MIN   = -64'sh8000_0000;
    localparam longint WHOLE_MAX = 64'sd32767;
    localparam longint WHOLE_MIN = -64'sd32768;

    typedef struct packed {
        logic [VAL_W-1:0] curve_value;
        logic             saturated;
    } segment_result_t;

    segment_result_t expected_curves[$];

    function automatic segment_result_t eval_segment(
        curve_op_t        op,
        logic             whole,
        logic [VAL_W-1:0] p0,
        logic [VAL_W-1:0] p1,
        logic [VAL_W-1:0] p2,
        logic [VAL_W-1:0] p3,
        logic [POS_W-1:0] pos
    );
        longint             tq, uq, t2, t3, u2, t2s;
        longint             wgt[4];
        logic [VAL_W-1:0]   pts[4];
        logic signed [99:0] acc, pv, wv, r;
        segment_result_t    res;
        tq  = (pos > POS_ONE) ? ONE_POS : longint'(pos);
        uq  = ONE_POS - tq;
        t2  = tq * tq;
        t3  = t2 * tq;
        u2  = uq * uq;
        t2s = t2 * ONE_POS;
        pts = '{p0, p1, p2, p3};
        case (op)
            OP_HOLD: begin
                wgt = '{ONE_W48, 0, 0, 0};
            end
            OP_LINEAR: begin
                wgt = '{uq * ONE_W32, 0, 0, tq * ONE_W32};
            end
            OP_BEZIER: begin
                wgt = '{u2 * uq, 3 * tq * u2, 3 * t2 * uq, t3};
            end
            default: begin
                wgt = '{2 * t3 - 3 * t2s + ONE_W48,
                        t3 - 2 * t2s + tq * ONE_W32,
                        t3 - t2s,
                        3 * t2s - 2 * t3};
            end
        endcase
        acc = '0;
        for (int i = 0; i < 4; i++) begin
            pv  = $signed(pts[i]);
            wv  = wgt[i];
            acc = acc + pv * wv;
        end
        res.saturated = 1'b0;
        if (whole) begin
            r = acc >>> 64;
            if (r < 0 && acc[63:0] != '0)
                r = r + 1;
            if (r > WHOLE_MAX) begin
                r = WHOLE_MAX;
                res.saturated = 1'b1;
            end
            if (r < WHOLE_MIN) begin
                r = WHOLE_MIN;
                res.saturated = 1'b1;
            end
            r = r <<< FRAC_W;
        end else begin
            r = (acc + (100'sd1 <<< 47)) >>> 48;
            if (r > Q16_MAX) begin
                r = Q16_MAX;
                res.saturated = 1'b1;
            end
            if (r < Q16_MIN) begin
                r = Q16_MIN;
                res.saturated = 1'b1;
            end
        end
        res.curve_value = r[VAL_W-1:0];
        return res;
    endfunction

    initial begin
        fail_count      = 0;
        pending         = 0;
        checked_count   = 0;
        saturated_count = 0;
    end

    always @(posedge aclk) begin
        segment_result_t want;
        if (!aresetn) begin
            expected_curves.delete();
        end else begin
            if (s_valid && s_ready)
                expected_curves.push_back(eval_segment(curve_op_t'(s_operation),
                    s_integer_track, s_left_value, s_left_out_tangent,
                    s_right_in_tangent, s_right_value, s_blend_position));
            if (m_valid && m_ready) begin
                if (expected_curves.size() == 0) begin
                    $error("unexpected result: curve_value %h saturated %b",
                           m_curve_value, m_saturated);
                    fail_count++;
                end else begin
                    want = expected_curves.pop_front();
                    checked_count++;
                    if (m_saturated)
                        saturated_count++;
                    if (m_curve_value !== want.curve_value) begin
                        $error("curve_value: expected %h, got %h",
                               want.curve_value, m_curve_value);
                        fail_count++;
                    end
                    if (m_saturated !== want.saturated) begin
                        $error("saturated: expected %b, got %b",
                               want.saturated, m_saturated);
                        fail_count++;
                    end
                end
            end
        end
        pending = expected_curves.size();
    end

endmodule

FILE: tb/tb_keyframe_curve_interpolator.sv
// ----------------------------------------------------------------------------
// tb_keyframe_curve_interpolator
// Drives curve segments into the interpolator: a directed set covering key
// value extremes, every curve mode, blend positions at and beyond one,
// rounding ties, truncation of negative integer tracks and saturation in
// both directions, then about a thousand random segments. Both channels
// idle at random, with some stretches at full rate.
// ----------------------------------------------------------------------------
module tb_keyframe_curve_interpolator import kci_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_SEGMENTS = 1000;
    localparam int STALL_LIMIT     = 2000;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    curve_op_t        s_operation = OP_HOLD;
    logic             s_integer_track = 1'b0;
    logic [VAL_W-1:0] s_left_value = '0;
    logic [VAL_W-1:0] s_left_out_tangent = '0;
    logic [VAL_W-1:0] s_right_in_tangent = '0;
    logic [VAL_W-1:0] s_right_value = '0;
    logic [POS_W-1:0] s_blend_position = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [VAL_W-1:0] m_curve_value;
    logic             m_saturated;

    int fail_count;
    int pending;
    int checked_count;
    int saturated_count;
    int segments_sent = 0;
    int idle_cycles = 0;
    bit no_idle = 1'b0;

    always #10 aclk = ~aclk;

    keyframe_curve_interpolator uut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_operation        (s_operation),
        .s_integer_track    (s_integer_track),
        .s_left_value       (s_left_value),
        .s_left_out_tangent (s_left_out_tangent),
        .s_right_in_tangent (s_right_in_tangent),
        .s_right_value      (s_right_value),
        .s_blend_position   (s_blend_position),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_curve_value      (m_curve_value),
        .m_saturated        (m_saturated)
    );

    curve_result_checker checker_i (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_operation        (s_operation),
        .s_integer_track    (s_integer_track),
        .s_left_value       (s_left_value),
        .s_left_out_tangent (s_left_out_tangent),
        .s_right_in_tangent (s_right_in_tangent),
        .s_right_value      (s_right_value),
        .s_blend_position   (s_blend_position),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_curve_value      (m_curve_value),
        .m_saturated        (m_saturated),
        .fail_count         (fail_count),
        .pending            (pending),
        .checked_count      (checked_count),
        .saturated_count    (saturated_count)
    );

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 16);
    endfunction

    function automatic logic [VAL_W-1:0] rand_key();
        logic [VAL_W-1:0] v;
        v = $urandom;
        case ($urandom_range(0, 3))
            0: return {{12{v[19]}}, v[19:0]};
            1: begin
                case (v[1:0])
                    2'd0: return 32'h8000_0000;
                    2'd1: return 32'h7FFF_FFFF;
                    2'd2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return v;
        endcase
    endfunction

    function automatic logic [POS_W-1:0] rand_position();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return POS_ONE;
            2: return POS_W'($urandom_range(65537, 131071));
            default: return POS_W'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic send_segment(
        curve_op_t        op,
        logic             whole,
        logic [VAL_W-1:0] p0,
        logic [VAL_W-1:0] p1,
        logic [VAL_W-1:0] p2,
        logic [VAL_W-1:0] p3,
        logic [POS_W-1:0] pos
    );
        int gap;
        gap = draw_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_operation        = op;
        s_integer_track    = whole;
        s_left_value       = p0;
        s_left_out_tangent = p1;
        s_right_in_tangent = p2;
        s_right_value      = p3;
        s_blend_position   = pos;
        s_valid            = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        segments_sent++;
    endtask

    initial begin
        int gap;
        forever begin
            @(negedge aclk);
            gap = draw_gap();
            if (gap > 0) begin
                m_ready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready = 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        curve_op_t op;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;

        send_segment(OP_HOLD, 1'b0, 32'h7FFF_FFFF, 32'h1234_5678, 32'h8000_0000,
                     32'hFFFF_FFFF, '0);
        send_segment(OP_HOLD, 1'b0, 32'h8000_0000, '0, '0, '0, POS_ONE);
        send_segment(OP_HOLD, 1'b1, 32'h7FFF_FFFF, '0, '0, '0, 17'd100);
        send_segment(OP_HOLD, 1'b1, 32'h8000_0000, '0, '0, '0, 17'd100);
        send_segment(OP_HOLD, 1'b1, 32'hFFFE_8000, '0, '0, '0, 17'd100);
        send_segment(OP_LINEAR, 1'b0, 32'h0001_0000, '0, '0, 32'h0005_0000, '0);
        send_segment(OP_LINEAR, 1'b0, 32'h0001_0000, '0, '0, 32'h0005_0000, POS_ONE);
        send_segment(OP_LINEAR, 1'b0, 32'h0001_0000, '0, '0, 32'h0005_0000,
                     17'h1FFFF);
        send_segment(OP_LINEAR, 1'b0, 32'h0000_0001, '0, '0, '0, 17'd32768);
        send_segment(OP_LINEAR, 1'b0, 32'hFFFF_FFFF, '0, '0, '0, 17'd32768);
        send_segment(OP_LINEAR, 1'b1, 32'hFFFC_8000, '0, '0, 32'hFFFC_8000, 17'd12345);
        send_segment(OP_LINEAR, 1'b0, 32'h8000_0000, '0, '0, 32'h7FFF_FFFF, 17'd1);
        send_segment(OP_LINEAR, 1'b0, 32'h7FFF_FFFF, '0, '0, 32'h8000_0000, 17'd65535);
        send_segment(OP_BEZIER, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h7FFF_FFFF, 17'd32768);
        send_segment(OP_BEZIER, 1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     32'h8000_0000, 17'd21845);
        send_segment(OP_BEZIER, 1'b0, '0, 32'h7FFF_FFFF, 32'h8000_0000, '0,
                     17'd32768);
        send_segment(OP_BEZIER, 1'b1, 32'hFFF0_4000, 32'h0003_8000, 32'hFFFF_0001,
                     32'h0020_0000, 17'd1);
        send_segment(OP_BEZIER, 1'b1, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                     32'hFFFB_0000, 17'd65537);
        send_segment(OP_HERMITE, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0,
                     32'h7FFF_FFFF, 17'd21845);
        send_segment(OP_HERMITE, 1'b0, 32'h8000_0000, 32'h8000_0000, '0,
                     32'h8000_0000, 17'd21845);
        send_segment(OP_HERMITE, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0,
                     32'h7FFF_FFFF, 17'd21845);
        send_segment(OP_HERMITE, 1'b1, 32'h8000_0000, 32'h8000_0000, '0,
                     32'h8000_0000, 17'd21845);
        send_segment(OP_HERMITE, 1'b0, '0, 32'h0001_0000, 32'h0001_0000,
                     32'h0002_0000, POS_ONE);
        send_segment(OP_HERMITE, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'h8000_0000, '0);

        for (int i = 0; i < RANDOM_SEGMENTS; i++) begin
            if (i % 200 == 0)
                no_idle = ((i / 200) % 2 == 1);
            op = curve_op_t'($urandom_range(0, 3));
            send_segment(op, 1'($urandom), rand_key(), rand_key(), rand_key(),
                         rand_key(), rand_position());
        end
        no_idle = 1'b0;

        @(negedge aclk);
        s_valid = 1'b0;
        wait (pending == 0);
        repeat (20) @(posedge aclk);

        $display("Sent %0d segments over hold, linear, Bezier and Hermite modes,",
                 segments_sent);
        $display("real and integer tracks; %0d results checked, %0d clamped.",
                 checked_count, saturated_count);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
